/* rtl/core/fpps_pkg.sv */
// Package for the flash page program sequencer: phase codes, bus op and
// target codes, command bytes and the result entry type.
// No dependencies.
`default_nettype none

package fpps_pkg;

  // Sequencer phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_FILL  = 3'd1;
  localparam logic [2:0] PH_POLL  = 3'd2;
  localparam logic [2:0] PH_CHECK = 3'd3;

  // Result operations
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_DONE  = 2'd2;

  // Register targets
  localparam logic [2:0] TG_CTRL   = 3'd0;
  localparam logic [2:0] TG_ADDR   = 3'd1;
  localparam logic [2:0] TG_CNT    = 3'd2;
  localparam logic [2:0] TG_CMD    = 3'd3;
  localparam logic [2:0] TG_PLO    = 3'd4;
  localparam logic [2:0] TG_PHI    = 3'd5;
  localparam logic [2:0] TG_STATUS = 3'd6;
  localparam logic [2:0] TG_ERROR  = 3'd7;

  // Input item kinds
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_ERROR_MASK   = 3'd0;
  localparam logic [2:0] CFG_DONE_MASK    = 3'd1;
  localparam logic [2:0] CFG_BUSY_MASK    = 3'd2;
  localparam logic [2:0] CFG_CLEAR_STATUS = 3'd3;
  localparam logic [2:0] CFG_BURST_BYTES  = 3'd4;
  localparam logic [2:0] CFG_BURST_OPCODE = 3'd5;
  localparam logic [2:0] CFG_PAGE_OPCODE  = 3'd6;

  // Command bytes
  localparam logic [31:0] CLEAR_STATUS = 32'h0000_00FA;
  localparam logic [31:0] ENTER_PAGE   = 32'h0000_0050;
  localparam logic [31:0] WRITE_FIRST  = 32'h0000_00A0;

  localparam logic [12:0] MIN_CHUNK    = 13'd32;
  localparam logic [12:0] MAX_BURST    = 13'd4096;
  localparam logic [12:0] RESET_BURST  = 13'd256;
  localparam logic [7:0]  RESET_BURST_OP = 8'd166;
  localparam logic [7:0]  RESET_PAGE_OP  = 8'd170;

  localparam int MAX_RES = 6;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  target;
    logic [31:0] value;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/flash_page_program_sequencer.sv */
// Flash page program sequencer top level: decodes each input item against the
// sequencer state and queues its bus results. Depends on fpps_pkg.
`default_nettype none

// Usage
//   Input channel (in_valid/in_stall): start, source data, status and error
//   reading items. Output channel (out_valid/out_stall): one bus write, read
//   request or finished result per beat, with last on the final beat of the
//   results an item causes (one to six).
//   Config channel (cfg_valid/cfg_ready): ready is always high; write only
//   while no results are pending.
//   An accepted item is decoded in the cycle it arrives and its results land
//   in the result bundle register, so its first result shows in the next cycle.
//   An item with n results occupies the bundle for n output beats; the next
//   item is taken in the cycle the last beat leaves, so items with one result
//   each flow at one per cycle while out_stall is low. An item with no
//   result still waits while earlier beats are pending, and leaves the bundle empty.
//   Out_stall holds the current beat; in_stall rises while the bundle still
//   holds beats that are not on their way out.
//   Reset (rst, synchronous) returns the sequencer to idle, drops pending
//   results and loads the register defaults.
module flash_page_program_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] dest_address,
  input  wire logic [31:0] byte_count,
  input  wire logic [31:0] value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       op,
  output logic [2:0]       target,
  output logic [31:0]      value_res,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Configuration registers
  logic [31:0] err_bits;
  logic [31:0] done_bits;
  logic [31:0] busy_bits;
  logic        clear_status_before_write;
  logic [12:0] burst_bytes;
  logic [7:0]  burst_opcode;
  logic [7:0]  page_opcode;

  // Sequencer state
  logic [2:0]  phase, phase_next;
  logic [31:0] cur_address, cur_address_next;
  logic [31:0] remaining_bytes, remaining_bytes_next;
  logic [12:0] chunk_bytes, chunk_bytes_next;
  logic [10:0] words_left, words_left_next;
  logic        high_half, high_half_next;

  // Result bundle
  fpps_pkg::res_t bundle [fpps_pkg::MAX_RES];
  fpps_pkg::res_t bundle_next [fpps_pkg::MAX_RES];
  logic [2:0]  cnt, cnt_next;
  logic [2:0]  idx;

  logic        in_acc, out_acc, out_final;
  logic [12:0] eff_burst;
  logic        burst_ok;
  logic [31:0] seq_addr, seq_rem;
  logic [12:0] new_chunk;
  logic [31:0] masked_count;
  logic [31:0] rem_after;
  logic [10:0] words_dec;
  logic        status_done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      err_bits                  <= '0;
      done_bits                 <= '0;
      busy_bits                 <= '0;
      clear_status_before_write <= 1'b0;
      burst_bytes               <= fpps_pkg::RESET_BURST;
      burst_opcode              <= fpps_pkg::RESET_BURST_OP;
      page_opcode               <= fpps_pkg::RESET_PAGE_OP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        fpps_pkg::CFG_ERROR_MASK:   err_bits <= cfg_data;
        fpps_pkg::CFG_DONE_MASK:    done_bits <= cfg_data;
        fpps_pkg::CFG_BUSY_MASK:    busy_bits <= cfg_data;
        fpps_pkg::CFG_CLEAR_STATUS: clear_status_before_write <= cfg_data[0];
        fpps_pkg::CFG_BURST_BYTES:  burst_bytes <= cfg_data[12:0];
        fpps_pkg::CFG_BURST_OPCODE: burst_opcode <= cfg_data[7:0];
        fpps_pkg::CFG_PAGE_OPCODE:  page_opcode <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Handshakes
  assign out_valid = (cnt != 3'd0);
  assign out_acc   = out_valid && !out_stall;
  assign last      = (idx == cnt - 3'd1);
  assign out_final = out_acc && last;
  assign in_stall  = out_valid && !out_final;
  assign in_acc    = in_valid && !in_stall;

  assign op        = bundle[idx].op;
  assign target    = bundle[idx].target;
  assign value_res = bundle[idx].value;

  // Burst sizes outside 32..4096 or not a power of two fall back to 32
  assign burst_ok  = (burst_bytes >= fpps_pkg::MIN_CHUNK) &&
                     (burst_bytes <= fpps_pkg::MAX_BURST) &&
                     ((burst_bytes & (burst_bytes - 13'd1)) == 13'd0);
  assign eff_burst = burst_ok ? burst_bytes : fpps_pkg::MIN_CHUNK;

  assign masked_count = {byte_count[31:5], 5'd0};
  assign rem_after    = (remaining_bytes >= {19'd0, chunk_bytes}) ?
                        remaining_bytes - {19'd0, chunk_bytes} : 32'd0;
  assign words_dec    = words_left - 11'd1;
  assign status_done  = (done_bits != 32'd0) ? ((value & done_bits) == done_bits)
                                             : ((value & busy_bits) == 32'd0);

  // Address and count a new chunk starts from: a start item or the next chunk
  assign seq_addr = (kind == fpps_pkg::KIND_START) ? dest_address
                                                   : cur_address + {19'd0, chunk_bytes};
  assign seq_rem  = (kind == fpps_pkg::KIND_START) ? masked_count : rem_after;
  assign new_chunk = ((seq_rem >= {19'd0, eff_burst}) &&
                      ((seq_addr & {19'd0, eff_burst - 13'd1}) == 32'd0)) ?
                     eff_burst : fpps_pkg::MIN_CHUNK;

  always_comb begin
    phase_next           = phase;
    cur_address_next     = cur_address;
    remaining_bytes_next = remaining_bytes;
    chunk_bytes_next     = chunk_bytes;
    words_left_next      = words_left;
    high_half_next       = high_half;
    cnt_next             = 3'd0;
    for (int i = 0; i < fpps_pkg::MAX_RES; i++) begin
      bundle_next[i] = '{op: fpps_pkg::OP_WRITE, target: fpps_pkg::TG_CTRL, value: 32'd0};
    end

    if (kind == fpps_pkg::KIND_START ||
        (kind == fpps_pkg::KIND_ERROR && phase == fpps_pkg::PH_CHECK &&
         (value & err_bits) == 32'd0)) begin
      cur_address_next     = seq_addr;
      remaining_bytes_next = seq_rem;
      if (seq_rem == 32'd0) begin
        phase_next     = fpps_pkg::PH_IDLE;
        cnt_next       = 3'd1;
        bundle_next[0] = '{op: fpps_pkg::OP_DONE, target: fpps_pkg::TG_CTRL, value: 32'd0};
      end else begin
        chunk_bytes_next = new_chunk;
        words_left_next  = new_chunk[12:2];
        high_half_next   = 1'b0;
        phase_next       = fpps_pkg::PH_FILL;
        cnt_next         = 3'd2;
        bundle_next[0]   = '{op: fpps_pkg::OP_WRITE, target: fpps_pkg::TG_CTRL,
                             value: fpps_pkg::CLEAR_STATUS};
        bundle_next[1]   = '{op: fpps_pkg::OP_WRITE, target: fpps_pkg::TG_CTRL,
                             value: fpps_pkg::ENTER_PAGE};
      end
    end else if (kind == fpps_pkg::KIND_ERROR && phase == fpps_pkg::PH_CHECK) begin
      // Error bits set: abort with the reading
      phase_next     = fpps_pkg::PH_IDLE;
      cnt_next       = 3'd1;
      bundle_next[0] = '{op: fpps_pkg::OP_DONE, target: fpps_pkg::TG_CTRL, value: value};
    end else if (kind == fpps_pkg::KIND_DATA && phase == fpps_pkg::PH_FILL) begin
      high_half_next  = !high_half;
      words_left_next = words_dec;
      cnt_next        = 3'd1;
      bundle_next[0]  = '{op: fpps_pkg::OP_WRITE,
                          target: high_half ? fpps_pkg::TG_PHI : fpps_pkg::TG_PLO,
                          value: value};
      if (words_dec == 11'd0) begin
        phase_next = fpps_pkg::PH_POLL;
        if (clear_status_before_write) begin
          cnt_next       = 3'd6;
          bundle_next[1] = '{op: fpps_pkg::OP_WRITE, target: fpps_pkg::TG_CTRL,
                             value: fpps_pkg::CLEAR_STATUS};
          bundle_next[2] = '{op: fpps_pkg::OP_WRITE, target: fpps_pkg::TG_ADDR,
                             value: cur_address};
          bundle_next[3] = '{op: fpps_pkg::OP_WRITE, target: fpps_pkg::TG_CNT, value: 32'd0};
          bundle_next[4] = '{op: fpps_pkg::OP_WRITE, target: fpps_pkg::TG_CMD,
                             value: fpps_pkg::WRITE_FIRST};
          bundle_next[5] = '{op: fpps_pkg::OP_WRITE, target: fpps_pkg::TG_CMD,
                             value: {24'd0, (chunk_bytes == eff_burst) ? burst_opcode
                                                                       : page_opcode}};
        end else begin
          cnt_next       = 3'd5;
          bundle_next[1] = '{op: fpps_pkg::OP_WRITE, target: fpps_pkg::TG_ADDR,
                             value: cur_address};
          bundle_next[2] = '{op: fpps_pkg::OP_WRITE, target: fpps_pkg::TG_CNT, value: 32'd0};
          bundle_next[3] = '{op: fpps_pkg::OP_WRITE, target: fpps_pkg::TG_CMD,
                             value: fpps_pkg::WRITE_FIRST};
          bundle_next[4] = '{op: fpps_pkg::OP_WRITE, target: fpps_pkg::TG_CMD,
                             value: {24'd0, (chunk_bytes == eff_burst) ? burst_opcode
                                                                       : page_opcode}};
        end
      end
    end else if (kind == fpps_pkg::KIND_STATUS && phase == fpps_pkg::PH_POLL &&
                 status_done) begin
      phase_next     = fpps_pkg::PH_CHECK;
      cnt_next       = 3'd1;
      bundle_next[0] = '{op: fpps_pkg::OP_READ, target: fpps_pkg::TG_ERROR, value: 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= fpps_pkg::PH_IDLE;
      cur_address     <= '0;
      remaining_bytes <= '0;
      chunk_bytes     <= '0;
      words_left      <= '0;
      high_half       <= 1'b0;
      cnt             <= '0;
      idx             <= '0;
    end else begin
      if (in_acc) begin
        phase           <= phase_next;
        cur_address     <= cur_address_next;
        remaining_bytes <= remaining_bytes_next;
        chunk_bytes     <= chunk_bytes_next;
        words_left      <= words_left_next;
        high_half       <= high_half_next;
        // Load the bundle; an item with no result leaves it empty
        cnt             <= cnt_next;
        idx             <= '0;
      end else if (out_final) begin
        cnt <= '0;
        idx <= '0;
      end else if (out_acc) begin
        idx <= idx + 3'd1;
      end
    end
  end

  // Bundle payload carries no reset
  always_ff @(posedge clk) begin
    if (in_acc && cnt_next != 3'd0) begin
      for (int i = 0; i < fpps_pkg::MAX_RES; i++) begin
        bundle[i] <= bundle_next[i];
      end
    end
  end

endmodule

`default_nettype wire
